[hdl/esc_pkg.sv]
// Shared types, register codes and constants of the sensor compensation pipeline.
package esc_pkg;

  // 32-bit two's-complement working word
  typedef logic signed [31:0] word_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_TEMP_ONE    = 3'd0,
    REG_TEMP_TWO    = 3'd1,
    REG_TEMP_THREE  = 3'd2,
    REG_HUM_ONE     = 3'd3,
    REG_HUM_TWO     = 3'd4,
    REG_HUM_PACKED  = 3'd5
  } cfg_reg_t;

  // Temperature calibration set
  typedef struct packed {
    logic        [15:0] one;
    logic signed [15:0] two;
    logic signed [7:0]  three;
  } temp_cfg_t;

  // Humidity calibration set; bytes holds h3..h7, h3 in the low byte
  typedef struct packed {
    logic [11:0] one;
    logic [11:0] two;
    logic [39:0] bytes;
  } hum_cfg_t;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 40;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 80;

  // Stage counts of the two halves and the whole pipeline
  localparam int TEMP_LAT = 5;
  localparam int HUM_LAT  = 16;
  localparam int PIPE_LAT = TEMP_LAT + HUM_LAT;

  // Unsigned 32-bit divide by 100: high product bits of n * M, shifted by 37
  localparam logic [31:0] DIV100_MUL   = 32'h51EB_851F;
  localparam int          DIV100_SHIFT = 37;

  localparam word_t TC_ROUND  = 32'sd128;
  localparam word_t HUM_BIAS  = 32'sd16384;
  localparam word_t HUM_SCALE = 32'sd1000;
  localparam word_t HUM_MAX   = 32'sd100000;

  // Sign-extend a calibration byte to a working word
  function automatic word_t sext8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

endpackage

[hdl/esc_div100.sv]
// Three-stage signed divide by 100, truncating toward zero, by reciprocal multiply.
module esc_div100 (
  input  logic          clk,
  input  logic          en,
  input  esc_pkg::word_t din,
  output esc_pkg::word_t dout
);
  import esc_pkg::*;

  logic        neg1_r, neg2_r;
  logic [31:0] mag_r, mag_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [31:0] quo;
  word_t       dout_r, dout_nxt;

  // Split sign and magnitude, multiply by reciprocal, restore sign
  always_comb begin
    mag_nxt  = din[31] ? (~din + 32'd1) : din;
    prod_nxt = 64'(mag_r) * 64'(DIV100_MUL);
    quo      = 32'(prod_r >> DIV100_SHIFT);
    dout_nxt = neg2_r ? (~quo + 32'd1) : quo;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r <= din[31];
      mag_r  <= mag_nxt;
      neg2_r <= neg1_r;
      prod_r <= prod_nxt;
      dout_r <= dout_nxt;
    end
  end

  assign dout = dout_r;

endmodule

[hdl/esc_temp.sv]
// Temperature compensation stages: fine temperature and hundredths of a degree.
module esc_temp (
  input  logic               clk,
  input  logic               en,
  input  logic [19:0]        raw_t,
  input  esc_pkg::temp_cfg_t cfg,
  output esc_pkg::word_t     fine,
  output esc_pkg::word_t     tc
);
  import esc_pkg::*;

  word_t a_r, a_nxt;
  word_t m1_r, hh_r, m1_nxt, hh_nxt, half;
  word_t b_r, q_r, b_nxt, q_nxt, hs;
  word_t fine_r, fine_nxt, qs;
  word_t fine5_r, tc_r, tc_sum, tc_nxt;
  word_t t2, t3x16;

  assign t2    = {{16{cfg.two[15]}}, cfg.two};
  assign t3x16 = sext8(cfg.three) <<< 4;

  always_comb begin
    // offset the raw word
    a_nxt    = {15'b0, raw_t[19:3]} - {15'b0, cfg.one, 1'b0};
    // linear term and square of the half offset
    half     = a_r >>> 1;
    m1_nxt   = a_r * t2;
    hh_nxt   = half * half;
    // scale both terms
    b_nxt    = m1_r >>> 11;
    hs       = hh_r >>> 12;
    q_nxt    = hs * t3x16;
    // sum into fine temperature
    qs       = q_r >>> 14;
    fine_nxt = b_r + qs;
    // centidegrees: (fine*5 + 128) >> 8
    tc_sum   = (fine_r <<< 2) + fine_r + TC_ROUND;
    tc_nxt   = tc_sum >>> 8;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r     <= a_nxt;
      m1_r    <= m1_nxt;
      hh_r    <= hh_nxt;
      b_r     <= b_nxt;
      q_r     <= q_nxt;
      fine_r  <= fine_nxt;
      fine5_r <= fine_r;
      tc_r    <= tc_nxt;
    end
  end

  assign fine = fine5_r;
  assign tc   = tc_r;

endmodule

[hdl/esc_hum.sv]
// Humidity compensation stages: calibrated and clamped humidity from centidegrees.
module esc_hum (
  input  logic              clk,
  input  logic              en,
  input  esc_pkg::word_t    tc,
  input  logic [15:0]       raw_h,
  input  esc_pkg::hum_cfg_t cfg,
  output logic [16:0]       hum
);
  import esc_pkg::*;

  word_t h3, h4, h5, h6, h7, c2x, h1x;

  // stage 1 products
  word_t x3_r, x4_r, x5_r, x7_r;
  // delay lines
  word_t tc_r [4];
  logic [15:0] rh_r [8];
  word_t d3_r [4];
  word_t d4_r [4];
  word_t d7_r [4];
  // divider outputs
  word_t d3, d4, d5, d7, d56;
  word_t e_r, e_nxt, es;
  // later stages
  word_t s_r, p1_r, p4_r, s_nxt, p1_nxt, p4_nxt, d3h, p4_sum, rh_ext;
  word_t p2_r, p1b_r, p4b_r, p2_nxt, p2_prod;
  word_t p3_r, p4c_r, p3_nxt;
  word_t p5a_r, p3b_r, p4d_r, p5a_nxt, p3s;
  word_t p6m_r, p3c_r, p6m_nxt, p5;
  word_t sum_r, sum_nxt, p6;
  word_t hm_r, hm_nxt, sums;
  word_t hv;
  logic [16:0] hum_r, hum_nxt;

  assign h3  = sext8(cfg.bytes[7:0]);
  assign h4  = sext8(cfg.bytes[15:8]);
  assign h5  = sext8(cfg.bytes[23:16]);
  assign h6  = sext8(cfg.bytes[31:24]);
  assign h7  = sext8(cfg.bytes[39:32]);
  assign c2x = {20'b0, cfg.two};
  assign h1x = {16'b0, cfg.one, 4'b0};

  // Divide the four coefficient products by 100
  esc_div100 u_div3 (.clk(clk), .en(en), .din(x3_r), .dout(d3));
  esc_div100 u_div4 (.clk(clk), .en(en), .din(x4_r), .dout(d4));
  esc_div100 u_div5 (.clk(clk), .en(en), .din(x5_r), .dout(d5));
  esc_div100 u_div7 (.clk(clk), .en(en), .din(x7_r), .dout(d7));

  // Shift the second-order term right by 6, then divide it by 100
  assign es = e_r >>> 6;
  esc_div100 u_div56 (.clk(clk), .en(en), .din(es), .dout(d56));

  always_comb begin
    e_nxt   = tc_r[3] * d5;
    // gather gain sum, offset term and quadratic coefficient
    s_nxt   = d4_r[3] + d56 + HUM_BIAS;
    d3h     = d3_r[3] >>> 1;
    rh_ext  = {16'b0, rh_r[7]};
    p1_nxt  = rh_ext - h1x - d3h;
    p4_sum  = (h6 <<< 7) + d7_r[3];
    p4_nxt  = p4_sum >>> 4;
    // gain
    p2_prod = c2x * s_r;
    p2_nxt  = p2_prod >>> 10;
    // main product and its square
    p3_nxt  = p1b_r * p2_r;
    p3s     = p3_r >>> 14;
    p5a_nxt = p3s * p3s;
    p5      = p5a_r >>> 10;
    p6m_nxt = p4d_r * p5;
    p6      = p6m_r >>> 1;
    sum_nxt = p3c_r + p6;
    sums    = sum_r >>> 10;
    hm_nxt  = sums * HUM_SCALE;
    hv      = hm_r >>> 12;
    // clamp to 0..100000
    if (hv < 0) begin
      hum_nxt = '0;
    end else if (hv > HUM_MAX) begin
      hum_nxt = HUM_MAX[16:0];
    end else begin
      hum_nxt = hv[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x3_r <= tc * h3;
      x4_r <= tc * h4;
      x5_r <= tc * h5;
      x7_r <= tc * h7;
      tc_r[0] <= tc;
      for (int i = 1; i < 4; i++) begin
        tc_r[i] <= tc_r[i-1];
      end
      rh_r[0] <= raw_h;
      for (int i = 1; i < 8; i++) begin
        rh_r[i] <= rh_r[i-1];
      end
      d3_r[0] <= d3;
      d4_r[0] <= d4;
      d7_r[0] <= d7;
      for (int i = 1; i < 4; i++) begin
        d3_r[i] <= d3_r[i-1];
        d4_r[i] <= d4_r[i-1];
        d7_r[i] <= d7_r[i-1];
      end
      e_r   <= e_nxt;
      s_r   <= s_nxt;
      p1_r  <= p1_nxt;
      p4_r  <= p4_nxt;
      p2_r  <= p2_nxt;
      p1b_r <= p1_r;
      p4b_r <= p4_r;
      p3_r  <= p3_nxt;
      p4c_r <= p4b_r;
      p5a_r <= p5a_nxt;
      p3b_r <= p3_r;
      p4d_r <= p4c_r;
      p6m_r <= p6m_nxt;
      p3c_r <= p3b_r;
      sum_r <= sum_nxt;
      hm_r  <= hm_nxt;
      hum_r <= hum_nxt;
    end
  end

  assign hum = hum_r;

endmodule

[hdl/env_sensor_compensation.sv]
// Top level of the sensor compensation pipeline: config registers, valid chain, output.
//
// Usage:
//   Input stream (in_*): one word per raw sample pair, 20-bit temperature ADC
//   value and 16-bit humidity ADC value. Output stream (out_*): one word per
//   input word, in order: fine temperature, temperature in 0.01 degC and
//   relative humidity in 0.001 %RH clamped to 0..100000.
//   Config port (cfg_*): write cfg_wdata to register cfg_addr on any clock
//   with cfg_we high; indexes above 5 are dropped. Write only while idle.
//   Pipeline: 5 temperature stages, then 16 humidity stages including two
//   chained divide-by-100 units.
//   Throughput: one word per cycle while the receiver takes them.
//   Stall: when out_tvalid is high and out_tready low the whole pipeline
//   holds and in_tready drops; nothing is lost or repeated.
//   Reset: rst_n low clears every valid bit and all coefficients to zero.
module env_sensor_compensation (
  input  logic                              clk,
  input  logic                              rst_n,
  // config write port
  input  logic                              cfg_we,
  input  logic [esc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [esc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [19:0] raw_temperature, [35:20] raw_humidity, [39:36] zero
  input  logic [esc_pkg::IN_DATA_W-1:0]     in_tdata,
  // output stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] fine_temperature, [55:32] temperature_centi,
  // [72:56] humidity_milli, [79:73] zero
  output logic [esc_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import esc_pkg::*;

  temp_cfg_t   tcfg_r;
  hum_cfg_t    hcfg_r;
  logic        en;
  logic [PIPE_LAT-1:0] vld_r;
  logic [15:0] rh_dly_r [TEMP_LAT];
  word_t       fine_dly_r [HUM_LAT];
  word_t       tc_dly_r [HUM_LAT];
  word_t       fine_t, tc_t;
  logic [16:0] hum;

  // Advance the whole pipeline unless the output word is stalled
  assign en        = !vld_r[PIPE_LAT-1] || out_tready;
  assign in_tready = en;

  // Config register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcfg_r <= '0;
      hcfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TEMP_ONE:   tcfg_r.one   <= cfg_wdata[15:0];
        REG_TEMP_TWO:   tcfg_r.two   <= cfg_wdata[15:0];
        REG_TEMP_THREE: tcfg_r.three <= cfg_wdata[7:0];
        REG_HUM_ONE:    hcfg_r.one   <= cfg_wdata[11:0];
        REG_HUM_TWO:    hcfg_r.two   <= cfg_wdata[11:0];
        REG_HUM_PACKED: hcfg_r.bytes <= cfg_wdata[39:0];
        default:        ;
      endcase
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_tvalid};
    end
  end

  esc_temp u_temp (
    .clk  (clk),
    .en   (en),
    .raw_t(in_tdata[19:0]),
    .cfg  (tcfg_r),
    .fine (fine_t),
    .tc   (tc_t)
  );

  // Align raw humidity with centidegrees, and temperature results with humidity
  always_ff @(posedge clk) begin
    if (en) begin
      rh_dly_r[0] <= in_tdata[35:20];
      for (int i = 1; i < TEMP_LAT; i++) begin
        rh_dly_r[i] <= rh_dly_r[i-1];
      end
      fine_dly_r[0] <= fine_t;
      tc_dly_r[0]   <= tc_t;
      for (int i = 1; i < HUM_LAT; i++) begin
        fine_dly_r[i] <= fine_dly_r[i-1];
        tc_dly_r[i]   <= tc_dly_r[i-1];
      end
    end
  end

  esc_hum u_hum (
    .clk  (clk),
    .en   (en),
    .tc   (tc_t),
    .raw_h(rh_dly_r[TEMP_LAT-1]),
    .cfg  (hcfg_r),
    .hum  (hum)
  );

  assign out_tvalid = vld_r[PIPE_LAT-1];
  assign out_tdata  = {7'b0, hum, tc_dly_r[HUM_LAT-1][23:0], fine_dly_r[HUM_LAT-1]};

  // Checks
  word_t chk_fine, chk_sum, chk_tc;
  assign chk_fine = out_tdata[31:0];
  assign chk_sum  = (chk_fine <<< 2) + chk_fine + TC_ROUND;
  assign chk_tc   = chk_sum >>> 8;

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[72:56] <= HUM_MAX[16:0])
    else $error("humidity above clamp limit");

  a_tc_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[55:32] == chk_tc[23:0])
    else $error("centidegrees do not follow fine temperature");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule
